// File: design/ipv6fp_pkg.sv
// Constants shared by the IPv6 fragment planner.
package ipv6fp_pkg;

  localparam int unsigned LenW = 16;
  localparam int unsigned ChunkW = 17;

  localparam logic [LenW-1:0] MtuReset      = 16'd1500;
  localparam logic [LenW-1:0] MtuMin        = 16'd1280;
  localparam logic [LenW-1:0] HdrLen        = 16'd40;
  localparam logic [LenW-1:0] FragOverhead  = 16'd48;
  localparam logic [LenW-1:0] FragHdrLen    = 16'd8;
  localparam logic [LenW-1:0] OffsetMask    = 16'hfff8;

endpackage

// File: design/ipv6_fragment_planner.sv
// IPv6 fragment planner: plans the fragments of an outgoing packet from its segment lengths.
//
// Each input item is one payload segment descriptor; the first segment of a packet also
// carries the packet's total payload length, which decides whole versus fragmented against
// the MTU register (values below 1280 act as 1280). While an item is in work the block is not
// ready. An item is loaded in the idle state; in the add step a whole-packet segment is finished
// and a fragmented packet's segment is added to the running chunk, then the compare step follows,
// where a single subtract-and-compare unit cuts one fragment at a time from the running chunk,
// holding while the result register is full and not taken. One result register separates the
// output; the next cut proceeds as soon as that register is taken. mtu_bytes is sampled per item.
module ipv6_fragment_planner
  import ipv6fp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // config: mtu_bytes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [15:0] total_length, [31:16] segment_length
  input  logic        s_axis_tlast_i,   // last_segment
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // [15:0] fragment_offset, [31:16] pay_len,
                                        // [32] more_fragments, [48:33] cut_position, rest 0
  output logic        m_axis_tuser_o,   // fragmented
  output logic        m_axis_tlast_o    // last_result
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_CMP
  } state_e;

  state_e              state_q, state_d;
  logic [LenW-1:0]     mtu_q, mtu_d;
  logic                in_packet_q, in_packet_d;
  logic                frag_q, frag_d;
  logic [ChunkW-1:0]   chunk_q, chunk_d;
  logic [LenW-1:0]     offset_q, offset_d;
  logic [LenW-1:0]     frag_lim_q, frag_lim_d;
  logic [LenW-1:0]     cut_size_q, cut_size_d;
  logic [LenW-1:0]     seg_q, seg_d;
  logic [LenW-1:0]     total_q, total_d;
  logic                last_q, last_d;

  logic                out_valid_q, out_valid_d;
  logic                out_frag_q, out_frag_d;
  logic [LenW-1:0]     out_off_q, out_off_d;
  logic [LenW-1:0]     out_plen_q, out_plen_d;
  logic                out_mf_q, out_mf_d;
  logic [LenW-1:0]     out_cut_q, out_cut_d;
  logic                out_last_q, out_last_d;

  logic [LenW-1:0]     mtu_eff;
  logic [LenW-1:0]     in_total;
  logic [LenW-1:0]     in_seg;
  logic                slot_free;
  logic                over;
  logic [ChunkW-1:0]   leftover;
  logic [LenW-1:0]     cut;

  assign in_total  = s_axis_tdata_i[15:0];
  assign in_seg    = s_axis_tdata_i[31:16];
  assign mtu_eff   = (mtu_q < MtuMin) ? MtuMin : mtu_q;
  assign slot_free = !out_valid_q || m_axis_tready_i;

  // shared cut unit
  assign over     = chunk_q > {1'b0, frag_lim_q};
  assign leftover = chunk_q - {1'b0, cut_size_q};
  assign cut      = (leftover <= {1'b0, seg_q}) ? (seg_q - leftover[LenW-1:0]) : '0;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_cut_q, out_mf_q, out_plen_q, out_off_q & OffsetMask};
  assign m_axis_tuser_o  = out_frag_q;
  assign m_axis_tlast_o  = out_last_q;

  always_comb begin
    state_d     = state_q;
    mtu_d       = mtu_q;
    in_packet_d = in_packet_q;
    frag_d      = frag_q;
    chunk_d     = chunk_q;
    offset_d    = offset_q;
    frag_lim_d  = frag_lim_q;
    cut_size_d  = cut_size_q;
    seg_d       = seg_q;
    total_d     = total_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_frag_d  = out_frag_q;
    out_off_d   = out_off_q;
    out_plen_d  = out_plen_q;
    out_mf_d    = out_mf_q;
    out_cut_d   = out_cut_q;
    out_last_d  = out_last_q;

    if (cfg_valid_i) begin
      mtu_d = cfg_data_i;
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          seg_d      = in_seg;
          last_d     = s_axis_tlast_i;
          total_d    = in_total;
          frag_lim_d = mtu_eff - FragOverhead;
          cut_size_d = (mtu_eff - FragOverhead) & OffsetMask;
          if (!in_packet_q) begin
            in_packet_d = 1'b1;
            frag_d      = !(({1'b0, in_total} + {1'b0, HdrLen}) < {1'b0, mtu_eff});
            chunk_d     = '0;
            offset_d    = '0;
          end
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        if (!frag_q) begin
          if (!last_q) begin
            state_d = S_IDLE;
          end else if (slot_free) begin
            out_valid_d = 1'b1;
            out_frag_d  = 1'b0;
            out_off_d   = '0;
            out_plen_d  = total_q;
            out_mf_d    = 1'b0;
            out_cut_d   = seg_q;
            out_last_d  = 1'b1;
            in_packet_d = 1'b0;
            state_d     = S_IDLE;
          end
        end else begin
          chunk_d = chunk_q + {1'b0, seg_q};
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (over) begin
          if (slot_free) begin
            out_valid_d = 1'b1;
            out_frag_d  = 1'b1;
            out_off_d   = offset_q;
            out_plen_d  = cut_size_q + FragHdrLen;
            out_mf_d    = 1'b1;
            out_cut_d   = cut;
            out_last_d  = (leftover <= {1'b0, frag_lim_q}) && !last_q;
            offset_d    = offset_q + cut_size_q;
            chunk_d     = leftover;
          end
        end else if (!last_q) begin
          state_d = S_IDLE;
        end else if (slot_free) begin
          out_valid_d = 1'b1;
          out_frag_d  = 1'b1;
          out_off_d   = offset_q;
          out_plen_d  = chunk_q[LenW-1:0] + FragHdrLen;
          out_mf_d    = 1'b0;
          out_cut_d   = seg_q;
          out_last_d  = 1'b1;
          in_packet_d = 1'b0;
          frag_d      = 1'b0;
          chunk_d     = '0;
          offset_d    = '0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mtu_q       <= MtuReset;
      in_packet_q <= 1'b0;
      frag_q      <= 1'b0;
      chunk_q     <= '0;
      offset_q    <= '0;
      frag_lim_q  <= MtuReset - FragOverhead;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mtu_q       <= mtu_d;
      in_packet_q <= in_packet_d;
      frag_q      <= frag_d;
      chunk_q     <= chunk_d;
      offset_q    <= offset_d;
      frag_lim_q  <= frag_lim_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cut_size_q <= cut_size_d;
    seg_q      <= seg_d;
    total_q    <= total_d;
    last_q     <= last_d;
    out_frag_q <= out_frag_d;
    out_off_q  <= out_off_d;
    out_plen_q <= out_plen_d;
    out_mf_q   <= out_mf_d;
    out_cut_q  <= out_cut_d;
    out_last_q <= out_last_d;
  end

  // open chunk never exceeds the fragment limit between items
  a_chunk_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (chunk_q <= {1'b0, frag_lim_q}))
    else $error("open chunk above fragment limit while idle");

  // a whole-packet result is a single, final result
  a_whole_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (!m_axis_tdata_o[32] && m_axis_tlast_o))
    else $error("whole-packet result with MF or not last");

  // final fragment closes the item's results
  a_final_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[32]) |-> m_axis_tlast_o)
    else $error("MF clear on a result that is not last");

  // no packet state kept for an unfragmented packet after its result
  a_idle_after_whole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADD && !frag_q && last_q && slot_free) |=> !in_packet_q)
    else $error("packet still open after whole-packet result");

endmodule

// File: bench/ipv6_fragment_planner_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the IPv6 fragment planner: segment stream in, fragment plans out.
module ipv6_fragment_planner_test;
  import ipv6fp_pkg::*;

  localparam int QuietLimit = 4000;
  localparam int HoldCycles = 400;

  typedef struct packed {
    logic        frag;
    logic [15:0] off;
    logic [15:0] plen;
    logic        mf;
    logic [15:0] cut;
    logic        lastr;
  } frag_plan_t;

  class fragment_plan_board;
    logic [15:0] mtu;
    bit          in_pkt;
    bit          splitting;
    logic [16:0] chunk;
    logic [15:0] offset;
    frag_plan_t  planned[$];
    int          errors;
    int          checked;

    function new();
      mtu = MtuReset;
      in_pkt = 1'b0;
      splitting = 1'b0;
      chunk = '0;
      offset = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void report_mismatch(string field, int got, int want);
      errors++;
      if (errors <= 40)
        $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, field, got, want);
    endfunction

    function void note_segment(logic [15:0] total, logic [15:0] seg, logic seg_last);
      logic [15:0] eff;
      logic [15:0] frag_lim;
      logic [15:0] cut_size;
      logic [16:0] leftover;
      int          first_new;
      frag_plan_t  p;
      eff = (mtu < MtuMin) ? MtuMin : mtu;
      frag_lim = eff - FragOverhead;
      cut_size = frag_lim & OffsetMask;
      first_new = planned.size();
      if (!in_pkt) begin
        in_pkt = 1'b1;
        splitting = ({1'b0, total} + {1'b0, HdrLen}) >= {1'b0, eff};
        chunk = '0;
        offset = '0;
      end
      if (!splitting) begin
        if (seg_last) begin
          p = '{frag: 1'b0, off: '0, plen: total, mf: 1'b0, cut: seg, lastr: 1'b1};
          planned = {planned, p};
          in_pkt = 1'b0;
        end
        return;
      end
      chunk = chunk + {1'b0, seg};
      while (chunk > {1'b0, frag_lim}) begin
        leftover = chunk - {1'b0, cut_size};
        p.frag = 1'b1;
        p.off = offset & OffsetMask;
        p.plen = cut_size + FragHdrLen;
        p.mf = 1'b1;
        p.cut = (leftover <= {1'b0, seg}) ? seg - leftover[15:0] : '0;
        p.lastr = 1'b0;
        planned = {planned, p};
        offset = offset + cut_size;
        chunk = leftover;
      end
      if (seg_last) begin
        p.frag = 1'b1;
        p.off = offset & OffsetMask;
        p.plen = chunk[15:0] + FragHdrLen;
        p.mf = 1'b0;
        p.cut = seg;
        p.lastr = 1'b0;
        planned = {planned, p};
        in_pkt = 1'b0;
        splitting = 1'b0;
        chunk = '0;
        offset = '0;
      end
      if (planned.size() > first_new)
        planned[planned.size() - 1].lastr = 1'b1;
    endfunction

    function void check_result(frag_plan_t got);
      frag_plan_t want;
      if (planned.size() == 0) begin
        report_mismatch("unexpected result, payload length", got.plen, 0);
        return;
      end
      want = planned.pop_front();
      checked++;
      if (got.frag !== want.frag) report_mismatch("fragmented", got.frag, want.frag);
      if (got.off !== want.off) report_mismatch("fragment_offset", got.off, want.off);
      if (got.plen !== want.plen) report_mismatch("pay_len", got.plen, want.plen);
      if (got.mf !== want.mf) report_mismatch("more_fragments", got.mf, want.mf);
      if (got.cut !== want.cut) report_mismatch("cut_position", got.cut, want.cut);
      if (got.lastr !== want.lastr) report_mismatch("last_result", got.lastr, want.lastr);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;   // [15:0] total_length, [31:16] segment_length
  logic        s_axis_tlast_i = 1'b0; // last_segment
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [55:0] m_axis_tdata_o;        // [15:0] offset, [31:16] pay_len, [32] MF,
                                      // [48:33] cut_position
  logic        m_axis_tuser_o;        // fragmented
  logic        m_axis_tlast_o;        // last_result

  fragment_plan_board sb;
  frag_plan_t         seen;
  int                 tx_idle_pct = 37;
  int                 rx_idle_pct = 58;
  int                 hold_len = 0;
  int                 held = 0;
  int                 quiet_cycles = 0;
  int                 items_sent = 0;
  int                 mtu_writes = 0;

  ipv6_fragment_planner i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // receiver: long hold-off on request, else random stalls
  always @(posedge clk_i) begin
    if (held < hold_len) begin
      m_axis_tready_i <= 1'b0;
      held <= held + 1;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      seen.frag = m_axis_tuser_o;
      seen.off = m_axis_tdata_o[15:0];
      seen.plen = m_axis_tdata_o[31:16];
      seen.mf = m_axis_tdata_o[32];
      seen.cut = m_axis_tdata_o[48:33];
      seen.lastr = m_axis_tlast_o;
      sb.check_result(seen);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i) || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("timeout: no item moved for %0d cycles", QuietLimit);
      $display("ipv6_fragment_planner_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_seg(input logic [15:0] total, input logic [15:0] seg, input logic seg_last);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {seg, total};
    s_axis_tlast_i <= seg_last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_segment(total, seg, seg_last);
    items_sent++;
  endtask

  // sender pauses until all planned results are out and the block has settled
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.planned.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_mtu(input logic [15:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.mtu = value;
    mtu_writes++;
  endtask

  task automatic send_random_packet();
    logic [15:0] total;
    logic [15:0] seg_total;
    int unsigned eff;
    int unsigned kind;
    int unsigned nseg;
    int unsigned left;
    int unsigned seg;
    bit          noisy;
    bit          seg_last;
    eff = {16'd0, ((sb.mtu < MtuMin) ? MtuMin : sb.mtu)};
    kind = $urandom_range(9);
    if (kind < 3) total = 16'($urandom_range(0, eff - 41));
    else if (kind < 8) total = 16'($urandom_range(eff - 40, 12000));
    else if (kind == 8) total = 16'($urandom_range(12000, 65535));
    else total = 16'(eff - 41 + $urandom_range(1));
    noisy = ($urandom_range(5) == 0);
    nseg = $urandom_range(1, 5);
    left = {16'd0, total};
    for (int i = 0; i < nseg; i++) begin
      if (noisy) seg = ($urandom_range(3) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 3000);
      else if (i == nseg - 1) seg = left;
      else seg = $urandom_range(0, left);
      left = (seg > left) ? 0 : left - seg;
      seg_last = (i == nseg - 1);
      seg_total = total;
      if (noisy) begin
        if ($urandom_range(3) == 0) seg_last = !seg_last;
        if (i != 0) seg_total = 16'($urandom_range(0, 65535));
      end
      send_seg(seg_total, seg[15:0], seg_last);
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset MTU 1500: whole packets, threshold, simple split, cut inside earlier segment
    send_seg(16'd0, 16'd0, 1'b1);
    send_seg(16'd1000, 16'd600, 1'b0);
    send_seg(16'hffff, 16'd400, 1'b1);
    send_seg(16'd1459, 16'd1459, 1'b1);
    send_seg(16'd1460, 16'd1460, 1'b1);
    send_seg(16'd3000, 16'd1450, 1'b0);
    send_seg(16'd0, 16'd5, 1'b0);
    send_seg(16'd0, 16'd1545, 1'b1);
    // MTU lowered in mid-packet
    send_seg(16'd5000, 16'd1000, 1'b0);
    write_mtu(MtuMin);
    send_seg(16'd0, 16'd4000, 1'b1);
    // largest segments, offset wraps
    send_seg(16'hffff, 16'hffff, 1'b0);
    send_seg(16'd0, 16'hffff, 1'b1);
    // MTU below the minimum acts as 1280, then the maximum MTU
    write_mtu(16'd0);
    send_seg(16'd1239, 16'd1239, 1'b1);
    send_seg(16'd1240, 16'd1240, 1'b1);
    write_mtu(16'hffff);
    send_seg(16'd65494, 16'd10, 1'b1);
    send_seg(16'd65495, 16'hffff, 1'b1);
    send_seg(16'hffff, 16'hffff, 1'b1);
    // MTU not a multiple of 8
    write_mtu(16'd1287);
    send_seg(16'd2000, 16'd1240, 1'b0);
    send_seg(16'd0, 16'd760, 1'b1);

    write_mtu(16'($urandom_range(1280, 2000)));
    while (items_sent < 110) send_random_packet();

    write_mtu(16'($urandom_range(1281, 9000)));
    tx_idle_pct = 58;
    rx_idle_pct = 37;
    while (items_sent < 190) send_random_packet();

    write_mtu(16'd1280 + 16'($urandom_range(7)));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_len = hold_len + HoldCycles;
    while (items_sent < 275) send_random_packet();

    drain();
    $display("covered %0d segment items and %0d fragment plans across %0d MTU writes,",
             items_sent, sb.checked, mtu_writes);
    $display("including clamped, minimum, odd and maximum MTU, offset wrap and a long stall");
    if (sb.errors == 0 && sb.planned.size() == 0) begin
      $display("ipv6_fragment_planner_test OK");
    end else begin
      $display("ipv6_fragment_planner_test NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/ipv6fp_pkg.sv
design/ipv6_fragment_planner.sv
bench/ipv6_fragment_planner_test.sv
